// ----- rtl/lrukv_pkg.sv -----
package lrukv_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam int unsigned CAPACITY_BITS = 4;
  localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 4'd8;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic empty;
  } status_t;

endpackage

// ----- rtl/lrukv_core.sv -----
module lrukv_core #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic                                 command,
  input  logic [KEY_BITS-1:0]                  lookup_key,
  input  logic [VALUE_BITS-1:0]                write_value,
  input  logic [lrukv_pkg::CAPACITY_BITS-1:0]  capacity,
  output lrukv_pkg::status_t                   status,
  output logic [VALUE_BITS-1:0]                read_value
);

  localparam int RW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > lrukv_pkg::CAPACITY_BITS) ? CW : lrukv_pkg::CAPACITY_BITS;

  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_r [ENTRIES];
  logic [RW-1:0]         rank_r  [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CW-1:0]         count_r;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    oldest;
  logic [ENTRIES-1:0]    free_oh;
  logic [ENTRIES-1:0]    target;
  logic [ENTRIES-1:0]    age;
  logic [VALUE_BITS-1:0] hit_value;
  logic [RW-1:0]         hit_rank;
  logic                  hit;
  logic                  is_set;
  logic                  do_insert;
  logic                  do_evict;
  logic [CMPW-1:0]       cap_ext;
  logic [CMPW-1:0]       eff_cap;

  // clamp capacity to 1..ENTRIES
  always_comb begin
    cap_ext = CMPW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == lookup_key);
      oldest[i] = valid_r[i] && ((CW'(rank_r[i]) + CW'(1)) == count_r);
      hit_value = hit_value | (value_r[i] & {VALUE_BITS{match[i]}});
      hit_rank  = hit_rank | (rank_r[i] & {RW{match[i]}});
    end
    // lowest free slot
    free_oh   = ~valid_r & (valid_r + ENTRIES'(1));
    hit       = |match;
    is_set    = (command == lrukv_pkg::CMD_SET);
    do_insert = !hit && is_set;
    do_evict  = do_insert && (CMPW'(count_r) >= eff_cap);
    if (hit) begin
      target = match;
    end else if (do_evict) begin
      target = oldest;
    end else begin
      target = free_oh;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      age[i] = valid_r[i] && !target[i] && (hit ? (rank_r[i] < hit_rank) : do_insert);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target[i] && (hit || do_insert)) begin
          rank_r[i] <= '0;
        end else if (age[i]) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
        if (target[i] && do_insert) begin
          valid_r[i] <= 1'b1;
        end
      end
      if (do_insert && !do_evict) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // key and value storage, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target[i] && do_insert) begin
          key_r[i] <= lookup_key;
        end
        if (target[i] && is_set) begin
          value_r[i] <= write_value;
        end
      end
    end
  end

  assign status.hit     = hit;
  assign status.evicted = do_evict;
  assign status.empty   = (count_r == '0);
  assign read_value     = (hit && !is_set) ? hit_value : '0;

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// an accepted item waits in the input stage registers, and its result is then registered in the output registers
// throughput: one item per cycle while the output is not stalled, set by the combinational key
// compare and recency update across all entries
// reset: all entries invalid, ranks and count cleared, capacity set to 8
// capacity writes are taken only while the store is empty
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [KEY_BITS-1:0]                  in_lookup_key,
  input  logic [VALUE_BITS-1:0]                in_write_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [VALUE_BITS-1:0]                out_read_value,
  output logic                                 out_evicted,
  input  logic                                 cfg_wr_en,
  input  logic [lrukv_pkg::CAPACITY_BITS-1:0]  cfg_wr_data
);

  logic [lrukv_pkg::CAPACITY_BITS-1:0] capacity_r;
  logic                                s1_valid_r;
  logic                                s1_command_r;
  logic [KEY_BITS-1:0]                 s1_key_r;
  logic [VALUE_BITS-1:0]               s1_value_r;
  logic                                out_valid_r;
  logic                                out_hit_r;
  logic                                out_evicted_r;
  logic [VALUE_BITS-1:0]               out_value_r;

  logic                                advance;
  logic                                fire;
  logic                                in_take;
  lrukv_pkg::status_t                  status;
  logic [VALUE_BITS-1:0]               core_value;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  lrukv_core #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .command     (s1_command_r),
    .lookup_key  (s1_key_r),
    .write_value (s1_value_r),
    .capacity    (capacity_r),
    .status      (status),
    .read_value  (core_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= lrukv_pkg::CAPACITY_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && status.empty) begin
        capacity_r <= cfg_wr_data;
      end
      // input stage is free when empty or when its item moves on
      if (!in_stall) begin
        s1_valid_r <= in_take;
      end
      if (advance) begin
        out_valid_r <= fire;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r <= in_command;
      s1_key_r     <= in_lookup_key;
      s1_value_r   <= in_write_value;
    end
    if (fire) begin
      out_hit_r     <= status.hit;
      out_evicted_r <= status.evicted;
      out_value_r   <= core_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_evicted    = out_evicted_r;
  assign out_read_value = out_value_r;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CACHE_SLOTS     = 8;
  localparam int KEY_W           = 16;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = lrukv_pkg::CAPACITY_BITS;
  localparam int POOL_SIZE       = 12;
  localparam int RANDOM_SEGMENTS = 10;
  localparam int SEGMENT_ITEMS   = 95;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 20;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } lookup_result_t;

  typedef struct {
    bit                        set_capacity;
    logic [CAP_W-1:0]          capacity;
    logic                      command;
    logic [KEY_W-1:0]          key;
    logic [VAL_W-1:0]          value;
    bit                        known;
    lookup_result_t            known_result;
  } access_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_command;
  logic [KEY_W-1:0]         in_lookup_key;
  logic [VAL_W-1:0]         in_write_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_hit;
  logic [VAL_W-1:0]         out_read_value;
  logic                     out_evicted;
  logic                     cfg_wr_en;
  logic [CAP_W-1:0]         cfg_wr_data;

  // shadow copy of the cache contents
  logic [KEY_W-1:0]         slot_key   [CACHE_SLOTS];
  logic [VAL_W-1:0]         slot_value [CACHE_SLOTS];
  bit                       slot_used  [CACHE_SLOTS];
  int                       slot_age   [CACHE_SLOTS];
  int                       used_count;
  logic [CAP_W-1:0]         capacity_reg;

  lookup_result_t           pending_results[$];
  access_row_t              directed_rows[$];
  logic [KEY_W-1:0]         key_pool[POOL_SIZE];

  int  fail_count;
  int  items_sent;
  int  hits_seen;
  int  evictions_seen;
  int  cycle_count;
  bit  hold_req;
  bit  no_gaps;

  lru_key_value_cache_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lru_key_value_cache_unit");
      $finish;
    end
  end

  function automatic int effective_capacity();
    int c;
    c = int'(capacity_reg);
    if (c < 1) c = 1;
    if (c > CACHE_SLOTS) c = CACHE_SLOTS;
    return c;
  endfunction

  // slot s becomes newest, valid slots younger than limit age by one
  function automatic void promote_slot(int s, int limit);
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (i != s && slot_used[i] && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic lookup_result_t cache_access(logic cmd, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] value);
    lookup_result_t res;
    int found;
    int slot;
    res = '0;
    found = -1;
    slot = -1;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (cmd == lrukv_pkg::CMD_GET) res.read_value = slot_value[found];
      else slot_value[found] = value;
      promote_slot(found, slot_age[found]);
    end else if (cmd == lrukv_pkg::CMD_SET) begin
      if (used_count >= effective_capacity()) begin
        // replace the oldest entry
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (slot < 0 && slot_used[i] && slot_age[i] + 1 == used_count) slot = i;
        end
        if (slot >= 0) begin
          res.evicted = 1'b1;
          slot_used[slot] = 1'b0;
          used_count--;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        promote_slot(slot, CACHE_SLOTS);
        slot_used[slot] = 1'b1;
        slot_key[slot] = key;
        slot_value[slot] = value;
        used_count++;
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("error: %s", what);
  endtask

  task automatic drive_item(input access_row_t row);
    lookup_result_t predicted;
    int gap;
    in_valid       <= 1'b1;
    in_command     <= row.command;
    in_lookup_key  <= row.key;
    in_write_value <= row.value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = cache_access(row.command, row.key, row.value);
    pending_results.push_back(row.known ? row.known_result : predicted);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // taken by the block only while the cache holds no entries
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    if (used_count == 0) capacity_reg = v;
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_row(input bit set_cap, input logic [CAP_W-1:0] cap,
                         input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value, input bit known,
                         input logic hit, input logic [VAL_W-1:0] rd, input logic ev);
    access_row_t row;
    row.set_capacity = set_cap;
    row.capacity     = cap;
    row.command      = cmd;
    row.key          = key;
    row.value        = value;
    row.known        = known;
    row.known_result = '{hit: hit, read_value: rd, evicted: ev};
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: hit %b read %h evicted %b",
                               out_hit, out_read_value, out_evicted));
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit || out_read_value !== want.read_value ||
            out_evicted !== want.evicted) begin
          note_failure($sformatf("expected hit %b read %h evicted %b, got %b %h %b",
                                 want.hit, want.read_value, want.evicted,
                                 out_hit, out_read_value, out_evicted));
        end
        if (out_hit === 1'b1) hits_seen++;
        if (out_evicted === 1'b1) evictions_seen++;
      end
    end
  end

  initial begin : receiver
    int stall_len;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int cap_pick;
    int span;
    access_row_t row;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = lrukv_pkg::CMD_GET;
    in_lookup_key  = '0;
    in_write_value = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    capacity_reg   = lrukv_pkg::CAPACITY_RESET;
    used_count     = 0;
    fail_count     = 0;
    items_sent     = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    cycle_count    = 0;
    hold_req       = 1'b0;
    no_gaps        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    cap_pick = $urandom_range(0, 15);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    // empty cache: every get misses
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0000, 32'h0000_0000, 1, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'hffff, 32'hffff_ffff, 1, 0, 32'h0, 0);
    add_row(1, 4'd15, lrukv_pkg::CMD_GET, 16'h1234, 32'h1357_9bdf, 1, 0, 32'h0, 0);
    add_row(1, 4'd0, lrukv_pkg::CMD_GET, 16'h8000, 32'h8000_0000, 1, 0, 32'h0, 0);
    // first insert never evicts, then update and read back
    add_row(1, CAP_W'(cap_pick), lrukv_pkg::CMD_SET, 16'h0000, 32'h0000_0000,
            1, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0000, 32'hdead_beef, 1, 1, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_SET, 16'h0000, 32'hffff_ffff, 1, 1, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0000, 32'h1234_5678, 1, 1, 32'hffff_ffff, 0);
    add_row(0, 0, lrukv_pkg::CMD_SET, 16'hffff, 32'ha5a5_a5a5, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'hffff, 32'h0000_0000, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0000, 32'h0000_0000, 0, 0, 32'h0, 0);
    // overfill so the oldest entries are evicted at any capacity
    for (int k = 1; k <= 8; k++) begin
      add_row(0, 0, lrukv_pkg::CMD_SET, 16'(k), 32'(32'h0101_0101 * k), 0, 0, 32'h0, 0);
    end
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0001, 32'h0, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0008, 32'h0, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_SET, 16'h0008, 32'h5a5a_5a5a, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_SET, 16'h4000, 32'h8000_0000, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'hffff, 32'h0, 0, 0, 32'h0, 0);
    add_row(0, 0, lrukv_pkg::CMD_GET, 16'h0004, 32'h0, 0, 0, 32'h0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_capacity) write_capacity(directed_rows[i].capacity);
      drive_item(directed_rows[i]);
    end

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      span = $urandom_range(1, POOL_SIZE - 1);
      no_gaps = (seg == 2);
      // long output hold while items keep coming
      if (seg == 4) hold_req = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        row.set_capacity = 1'b0;
        row.capacity     = '0;
        row.known        = 1'b0;
        row.known_result = '0;
        row.command      = $urandom_range(0, 1) ? lrukv_pkg::CMD_SET : lrukv_pkg::CMD_GET;
        if ($urandom_range(0, 4) == 0) row.key = KEY_W'($urandom);
        else row.key = key_pool[$urandom_range(0, span)];
        row.value = $urandom;
        drive_item(row);
      end
      no_gaps = 1'b0;
      if (seg == 6) drain();
      // cache is no longer empty, so these writes must not take
      if (seg == 3) write_capacity(4'd1);
      if (seg == 7) write_capacity(4'd15);
      if (seg == 8) write_capacity(4'd0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("ran %0d items (%0d from the table), saw %0d hits and %0d evictions",
             items_sent, directed_rows.size(), hits_seen, evictions_seen);
    $display("capacity settled at %0d on the empty cache (written %0d), later writes ignored",
             effective_capacity(), cap_pick);
    if (fail_count == 0) begin
      $display("PASS lru_key_value_cache_unit");
    end else begin
      $display("FAIL lru_key_value_cache_unit");
    end
    $finish;
  end

endmodule

// ----- lru_key_value_cache_unit.f -----
rtl/lrukv_pkg.sv
rtl/lrukv_core.sv
rtl/lru_key_value_cache_unit.sv
test/tb.sv
